// ----- rtl/core/ttpc_pkg.sv -----
package ttpc_pkg;

   // Default coordinate width of the pixel ports.
   localparam int COORD_BITS_DEF = 12;

   // Configuration field widths.
   localparam int SIDE_W   = 12;
   localparam int HALF_W   = 11;
   localparam int HT_W     = 12;
   localparam int COLOUR_W = 24;

   // Register port geometry.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Internal arithmetic widths.
   localparam int PROD_W    = 23;  // nr * H and yr * h
   localparam int JNUM_W    = 24;  // yr * side + H
   localparam int D12_DEN_W = 24;  // 2 * h * H
   localparam int D12_W     = 16;  // face weight toward the second corner
   localparam int D13_W     = 17;  // face weight toward the third corner, may reach 65536
   localparam int JMID_W    = 12;  // midline column of the band row
   localparam int JDEN_W    = 13;  // 2 * H
   localparam int WGT_W     = 17;  // Q16 weight up to and including 1.0
   localparam int LABEL_W   = 2;

   // Register stages outside the dividers.
   localparam int GEOM_STAGES  = 2;
   localparam int SHADE_STAGES = 3;

   // Register reset values.
   localparam logic [SIDE_W-1:0]   SIDE_LEN_RST    = SIDE_W'(64);
   localparam logic [HT_W-1:0]     TRI_HEIGHT_RST  = HT_W'(55);
   localparam logic [COLOUR_W-1:0] COLOUR_A_RST    = 24'hFF0000;
   localparam logic [COLOUR_W-1:0] COLOUR_B_RST    = 24'h00FF00;
   localparam logic [COLOUR_W-1:0] COLOUR_C_RST    = 24'h0000FF;
   localparam logic [COLOUR_W-1:0] COLOUR_D_RST    = 24'hFFFFFF;

   // Register map, one word per register.
   typedef enum logic [2:0] {
      REG_SIDE_LEN    = 3'd0,
      REG_TRI_HEIGHT  = 3'd1,
      REG_EDGE_MARK   = 3'd2,
      REG_VERTEX_MODE = 3'd3,
      REG_COLOUR_A    = 3'd4,
      REG_COLOUR_B    = 3'd5,
      REG_COLOUR_C    = 3'd6,
      REG_COLOUR_D    = 3'd7
   } reg_idx_type;

   // Corner colour slots, in label order 1, 2, 4, 8.
   typedef enum logic [1:0] {
      SLOT_A = 2'd0,
      SLOT_B = 2'd1,
      SLOT_C = 2'd2,
      SLOT_D = 2'd3
   } slot_type;

   // Label masks of the triangles that miss one corner colour.
   localparam logic [3:0] MASK_NO_A = 4'd14;
   localparam logic [3:0] MASK_NO_B = 4'd13;
   localparam logic [3:0] MASK_NO_C = 4'd11;

   // Effective configuration handed to the pipeline.
   typedef struct packed {
      logic [HT_W-1:0]                hh;
      logic [HALF_W-1:0]              h;
      logic [SIDE_W-1:0]              side;
      logic                           edge_mark;
      logic                           vertex_mode;
      logic [3:0][COLOUR_W-1:0]       colour;
   } cfg_type;

   // Corner label index from the low bits of the lattice coordinates.
   function automatic logic [LABEL_W-1:0] corner_label(input logic [1:0] x,
                                                      input logic [1:0] y);
      return {x[1], 1'b0} + y;
   endfunction

   // Accept-to-result latency in cycles.
   function automatic int latency(input int coord_bits);
      return 2 * coord_bits + D12_W + D13_W + JMID_W + GEOM_STAGES + SHADE_STAGES;
   endfunction

endpackage

// ----- rtl/core/triangle_tiling_pixel_colour_unit.sv -----
// Latency is measured from start to rsp_valid.
// Throughput: one pixel per clock; busy is never raised and results cannot be held off.
// The latency is set by five pipelined restoring dividers that resolve one quotient
// bit per register stage, plus two geometry stages and three shading stages.
// Synchronous reset clears all valid bits and loads the register defaults.
module triangle_tiling_pixel_colour_unit #(
   parameter int COORD_BITS = ttpc_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [COORD_BITS-1:0]         req_pix_row,
   input  logic [COORD_BITS-1:0]         req_pix_col,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ttpc_pkg::ADDR_W-1:0]   paddr,
   input  logic [ttpc_pkg::DATA_W-1:0]   pwdata,
   output logic [ttpc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int HT_W   = ttpc_pkg::HT_W;
   localparam int HALF_W = ttpc_pkg::HALF_W;
   localparam int LAB3_W = 3 * ttpc_pkg::LABEL_W;

   // Configuration registers.
   logic [ttpc_pkg::SIDE_W-1:0]       side_len_ff;
   logic [HT_W-1:0]                   tri_height_ff;
   logic                              edge_mark_ff;
   logic                              vertex_mode_ff;
   logic [3:0][ttpc_pkg::COLOUR_W-1:0] colour_ff;
   ttpc_pkg::reg_idx_type             reg_idx;
   logic                              wr_en;

   assign reg_idx = ttpc_pkg::reg_idx_type'(paddr[ttpc_pkg::ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign busy    = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_len_ff    <= ttpc_pkg::SIDE_LEN_RST;
         tri_height_ff  <= ttpc_pkg::TRI_HEIGHT_RST;
         edge_mark_ff   <= 1'b0;
         vertex_mode_ff <= 1'b0;
         colour_ff[0]   <= ttpc_pkg::COLOUR_A_RST;
         colour_ff[1]   <= ttpc_pkg::COLOUR_B_RST;
         colour_ff[2]   <= ttpc_pkg::COLOUR_C_RST;
         colour_ff[3]   <= ttpc_pkg::COLOUR_D_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            ttpc_pkg::REG_SIDE_LEN:    side_len_ff    <= pwdata[ttpc_pkg::SIDE_W-1:0];
            ttpc_pkg::REG_TRI_HEIGHT:  tri_height_ff  <= pwdata[HT_W-1:0];
            ttpc_pkg::REG_EDGE_MARK:   edge_mark_ff   <= pwdata[0];
            ttpc_pkg::REG_VERTEX_MODE: vertex_mode_ff <= pwdata[0];
            ttpc_pkg::REG_COLOUR_A:    colour_ff[0]   <= pwdata[ttpc_pkg::COLOUR_W-1:0];
            ttpc_pkg::REG_COLOUR_B:    colour_ff[1]   <= pwdata[ttpc_pkg::COLOUR_W-1:0];
            ttpc_pkg::REG_COLOUR_C:    colour_ff[2]   <= pwdata[ttpc_pkg::COLOUR_W-1:0];
            ttpc_pkg::REG_COLOUR_D:    colour_ff[3]   <= pwdata[ttpc_pkg::COLOUR_W-1:0];
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (reg_idx)
         ttpc_pkg::REG_SIDE_LEN:    prdata = ttpc_pkg::DATA_W'(side_len_ff);
         ttpc_pkg::REG_TRI_HEIGHT:  prdata = ttpc_pkg::DATA_W'(tri_height_ff);
         ttpc_pkg::REG_EDGE_MARK:   prdata = ttpc_pkg::DATA_W'(edge_mark_ff);
         ttpc_pkg::REG_VERTEX_MODE: prdata = ttpc_pkg::DATA_W'(vertex_mode_ff);
         ttpc_pkg::REG_COLOUR_A:    prdata = ttpc_pkg::DATA_W'(colour_ff[0]);
         ttpc_pkg::REG_COLOUR_B:    prdata = ttpc_pkg::DATA_W'(colour_ff[1]);
         ttpc_pkg::REG_COLOUR_C:    prdata = ttpc_pkg::DATA_W'(colour_ff[2]);
         ttpc_pkg::REG_COLOUR_D:    prdata = ttpc_pkg::DATA_W'(colour_ff[3]);
      endcase
   end

   // Effective configuration: a zero height or half side counts as one.
   ttpc_pkg::cfg_type                cfg;
   logic [HALF_W-1:0]                half_raw;
   logic [ttpc_pkg::D12_DEN_W-1:0]   d12_den_ff;

   assign half_raw         = side_len_ff[ttpc_pkg::SIDE_W-1:1];
   assign cfg.hh           = (tri_height_ff == '0) ? HT_W'(1) : tri_height_ff;
   assign cfg.h            = (half_raw == '0) ? HALF_W'(1) : half_raw;
   assign cfg.side         = side_len_ff;
   assign cfg.edge_mark    = edge_mark_ff;
   assign cfg.vertex_mode  = vertex_mode_ff;
   assign cfg.colour       = colour_ff;

   // The blend denominator only moves with configuration, so it is registered.
   always_ff @(posedge clock) begin
      d12_den_ff <= {ttpc_pkg::PROD_W'(cfg.h * cfg.hh), 1'b0};
   end

   // Row divided by the band height.
   logic                   rd_valid;
   logic [COORD_BITS-1:0]  rd_yi;
   logic [HT_W-1:0]        rd_yr;
   logic [COORD_BITS-1:0]  rd_col;

   ttpc_div #(.DW(HT_W), .QW(COORD_BITS), .PW(COORD_BITS)) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_rem    ('0),
      .in_num    (req_pix_row),
      .divisor   (cfg.hh),
      .in_pay    (req_pix_col),
      .out_valid (rd_valid),
      .out_quo   (rd_yi),
      .out_rem   (rd_yr),
      .out_pay   (rd_col)
   );

   // Column divided by half the side.
   logic                   cd_valid;
   logic [COORD_BITS-1:0]  cd_xi;
   logic [HALF_W-1:0]      cd_xr;
   logic [HT_W+1:0]        cd_pay;

   ttpc_div #(.DW(HALF_W), .QW(COORD_BITS), .PW(HT_W + 2)) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .in_rem    ('0),
      .in_num    (rd_col),
      .divisor   (cfg.h),
      .in_pay    ({rd_yi[1:0], rd_yr}),
      .out_valid (cd_valid),
      .out_quo   (cd_xi),
      .out_rem   (cd_xr),
      .out_pay   (cd_pay)
   );

   // Geometry of the containing triangle.
   logic                             g_valid;
   logic [LAB3_W-1:0]                g_labels;
   logic                             g_yz;
   logic [HALF_W-1:0]                g_nr;
   logic [ttpc_pkg::PROD_W-1:0]      g_diff;
   logic [HT_W-1:0]                  g_t;
   logic [ttpc_pkg::JNUM_W-1:0]      g_jnum;

   ttpc_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (cd_valid),
      .in_yi      (cd_pay[HT_W+1:HT_W]),
      .in_yr      (cd_pay[HT_W-1:0]),
      .in_xi      (cd_xi[1:0]),
      .in_xr      (cd_xr),
      .out_valid  (g_valid),
      .out_labels (g_labels),
      .out_yz     (g_yz),
      .out_nr     (g_nr),
      .out_diff   (g_diff),
      .out_t      (g_t),
      .out_jnum   (g_jnum)
   );

   // Weight toward the second corner: diff * 65536 / (2 * h * H).
   localparam int P12_W = LAB3_W + 1 + HALF_W + HT_W + ttpc_pkg::JNUM_W;

   logic                         a_valid;
   logic [ttpc_pkg::D12_W-1:0]   a_d12;
   logic [P12_W-1:0]             a_pay;
   logic [LAB3_W-1:0]            a_labels;
   logic                         a_yz;
   logic [HALF_W-1:0]            a_nr;
   logic [HT_W-1:0]              a_t;
   logic [ttpc_pkg::JNUM_W-1:0]  a_jnum;

   ttpc_div #(.DW(ttpc_pkg::D12_DEN_W), .QW(ttpc_pkg::D12_W), .PW(P12_W)) u_d12_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_rem    (ttpc_pkg::D12_DEN_W'(g_diff)),
      .in_num    ('0),
      .divisor   (d12_den_ff),
      .in_pay    ({g_labels, g_yz, g_nr, g_t, g_jnum}),
      .out_valid (a_valid),
      .out_quo   (a_d12),
      .out_rem   (),
      .out_pay   (a_pay)
   );

   assign {a_labels, a_yz, a_nr, a_t, a_jnum} = a_pay;

   // Weight toward the third corner: t * 65536 / H, one extra bit for the full weight.
   localparam int P13_W = LAB3_W + 1 + HALF_W + ttpc_pkg::JNUM_W + ttpc_pkg::D12_W;

   logic                         b_valid;
   logic [ttpc_pkg::D13_W-1:0]   b_d13;
   logic [P13_W-1:0]             b_pay;
   logic [LAB3_W-1:0]            b_labels;
   logic                         b_yz;
   logic [HALF_W-1:0]            b_nr;
   logic [ttpc_pkg::JNUM_W-1:0]  b_jnum;
   logic [ttpc_pkg::D12_W-1:0]   b_d12;

   ttpc_div #(.DW(HT_W), .QW(ttpc_pkg::D13_W), .PW(P13_W)) u_d13_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_rem    ({1'b0, a_t[HT_W-1:1]}),
      .in_num    ({a_t[0], 16'h0000}),
      .divisor   (cfg.hh),
      .in_pay    ({a_labels, a_yz, a_nr, a_jnum, a_d12}),
      .out_valid (b_valid),
      .out_quo   (b_d13),
      .out_rem   (),
      .out_pay   (b_pay)
   );

   assign {b_labels, b_yz, b_nr, b_jnum, b_d12} = b_pay;

   // Midline column: (yr * side + H) / (2 * H).
   localparam int PJ_W = LAB3_W + 1 + HALF_W + ttpc_pkg::D12_W + ttpc_pkg::D13_W;

   logic                         j_valid;
   logic [ttpc_pkg::JMID_W-1:0]  j_jmid;
   logic [PJ_W-1:0]              j_pay;
   logic [LAB3_W-1:0]            j_labels;
   logic                         j_yz;
   logic [HALF_W-1:0]            j_nr;
   logic [ttpc_pkg::D12_W-1:0]   j_d12;
   logic [ttpc_pkg::D13_W-1:0]   j_d13;

   ttpc_div #(.DW(ttpc_pkg::JDEN_W), .QW(ttpc_pkg::JMID_W), .PW(PJ_W)) u_jmid_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_rem    ({1'b0, b_jnum[ttpc_pkg::JNUM_W-1:ttpc_pkg::JMID_W]}),
      .in_num    (b_jnum[ttpc_pkg::JMID_W-1:0]),
      .divisor   ({cfg.hh, 1'b0}),
      .in_pay    ({b_labels, b_yz, b_nr, b_d12, b_d13}),
      .out_valid (j_valid),
      .out_quo   (j_jmid),
      .out_rem   (),
      .out_pay   (j_pay)
   );

   assign {j_labels, j_yz, j_nr, j_d12, j_d13} = j_pay;

   // Colour and result beat.
   ttpc_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (j_valid),
      .in_labels (j_labels),
      .in_yz     (j_yz),
      .in_nr     (j_nr),
      .in_d12    (j_d12),
      .in_d13    (j_d13),
      .in_jmid   (j_jmid),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

// ----- rtl/core/ttpc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// The caller guarantees in_rem < divisor, so the quotient fits QW bits.
module ttpc_div #(
   parameter int DW = 12,
   parameter int QW = 12,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_num,
   input  logic [DW-1:0] divisor,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [PW-1:0] out_pay
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] num_ff   [QW];
   logic [PW-1:0] pay_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          v_prev;
      logic [DW-1:0] r_prev;
      logic [QW-1:0] n_prev;
      logic [PW-1:0] p_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] num_in;

      if (i == 0) begin : g_first
         assign v_prev = in_valid;
         assign r_prev = in_rem;
         assign n_prev = in_num;
         assign p_prev = in_pay;
      end else begin : g_next
         assign v_prev = valid_ff[i-1];
         assign r_prev = rem_ff[i-1];
         assign n_prev = num_ff[i-1];
         assign p_prev = pay_ff[i-1];
      end

      // Shift in the next numerator bit and subtract when it fits.
      // The quotient bit enters the numerator register from the bottom.
      assign trial  = {r_prev, n_prev[QW-1]};
      assign ge     = (trial >= {1'b0, divisor});
      assign rem_in = ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      assign num_in = {n_prev[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         num_ff[i] <= num_in;
         pay_ff[i] <= p_prev;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = num_ff[QW-1];
   assign out_rem   = rem_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

// ----- rtl/core/ttpc_geom.sv -----
// Triangle geometry: mirrored column fraction, orientation, corner labels
// and the numerators of the blend weights and of the midline column.
module ttpc_geom (
   input  logic                                clock,
   input  logic                                reset,
   input  ttpc_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   input  logic [1:0]                          in_yi,
   input  logic [ttpc_pkg::HT_W-1:0]           in_yr,
   input  logic [1:0]                          in_xi,
   input  logic [ttpc_pkg::HALF_W-1:0]         in_xr,
   output logic                                out_valid,
   output logic [3*ttpc_pkg::LABEL_W-1:0]      out_labels,
   output logic                                out_yz,
   output logic [ttpc_pkg::HALF_W-1:0]         out_nr,
   output logic [ttpc_pkg::PROD_W-1:0]         out_diff,
   output logic [ttpc_pkg::HT_W-1:0]           out_t,
   output logic [ttpc_pkg::JNUM_W-1:0]         out_jnum
);

   // Stage one: mirror the column and form the products.
   logic                          v1_ff;
   logic                          odd1_ff;
   logic [ttpc_pkg::HALF_W-1:0]   nr1_ff;
   logic [ttpc_pkg::HT_W-1:0]     yr1_ff;
   logic [1:0]                    yi1_ff;
   logic [1:0]                    xi1_ff;
   logic [ttpc_pkg::PROD_W-1:0]   p1_ff;
   logic [ttpc_pkg::PROD_W-1:0]   p2_ff;
   logic [ttpc_pkg::JNUM_W-1:0]   js_ff;

   logic                          odd1_in;
   logic [ttpc_pkg::HALF_W-1:0]   nr1_in;

   assign odd1_in = in_xi[0] ^ in_yi[0];
   assign nr1_in  = odd1_in ? ttpc_pkg::HALF_W'(cfg.h - in_xr) : in_xr;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      odd1_ff <= odd1_in;
      nr1_ff  <= nr1_in;
      yr1_ff  <= in_yr;
      yi1_ff  <= in_yi;
      xi1_ff  <= in_xi;
      p1_ff   <= ttpc_pkg::PROD_W'(nr1_in * cfg.hh);
      p2_ff   <= ttpc_pkg::PROD_W'(in_yr * cfg.h);
      js_ff   <= ttpc_pkg::JNUM_W'(in_yr * cfg.side);
   end

   // Stage two: orientation, corner labels and the weight and midline numerators.
   logic                              down2;
   logic [1:0]                        xb2;
   logic [1:0]                        xs2;
   logic [1:0]                        yn2;
   logic [ttpc_pkg::LABEL_W-1:0]      l1_2;
   logic [ttpc_pkg::LABEL_W-1:0]      l2_2;
   logic [ttpc_pkg::LABEL_W-1:0]      l3_2;

   logic                              v2_ff;
   logic [3*ttpc_pkg::LABEL_W-1:0]    labels_ff;
   logic                              yz_ff;
   logic [ttpc_pkg::HALF_W-1:0]       nr2_ff;
   logic [ttpc_pkg::PROD_W-1:0]       diff_ff;
   logic [ttpc_pkg::HT_W-1:0]         t_ff;
   logic [ttpc_pkg::JNUM_W-1:0]       jnum_ff;

   assign down2 = (p1_ff > p2_ff);
   assign xb2   = xi1_ff + {1'b0, odd1_ff};
   assign xs2   = odd1_ff ? 2'b11 : 2'b01;
   assign yn2   = yi1_ff + 2'b01;

   always_comb begin
      if (down2) begin
         l1_2 = ttpc_pkg::corner_label(xb2, yi1_ff);
         l2_2 = ttpc_pkg::corner_label(xb2 + {xs2[0], 1'b0}, yi1_ff);
         l3_2 = ttpc_pkg::corner_label(xb2 + xs2, yn2);
      end else begin
         l1_2 = ttpc_pkg::corner_label(xb2 + xs2, yn2);
         l2_2 = ttpc_pkg::corner_label(xb2 - xs2, yn2);
         l3_2 = ttpc_pkg::corner_label(xb2, yi1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      labels_ff <= {l1_2, l2_2, l3_2};
      yz_ff     <= (yr1_ff == '0);
      nr2_ff    <= nr1_ff;
      diff_ff   <= down2 ? (p1_ff - p2_ff) : (p2_ff - p1_ff);
      t_ff      <= down2 ? yr1_ff : ttpc_pkg::HT_W'(cfg.hh - yr1_ff);
      jnum_ff   <= js_ff + ttpc_pkg::JNUM_W'(cfg.hh);
   end

   assign out_valid  = v2_ff;
   assign out_labels = labels_ff;
   assign out_yz     = yz_ff;
   assign out_nr     = nr2_ff;
   assign out_diff   = diff_ff;
   assign out_t      = t_ff;
   assign out_jnum   = jnum_ff;

endmodule

// ----- rtl/core/ttpc_shade.sv -----
// Colour stage: edge test, face colour pick, corner blend and output register.
module ttpc_shade (
   input  logic                                clock,
   input  logic                                reset,
   input  ttpc_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   input  logic [3*ttpc_pkg::LABEL_W-1:0]      in_labels,
   input  logic                                in_yz,
   input  logic [ttpc_pkg::HALF_W-1:0]         in_nr,
   input  logic [ttpc_pkg::D12_W-1:0]          in_d12,
   input  logic [ttpc_pkg::D13_W-1:0]          in_d13,
   input  logic [ttpc_pkg::JMID_W-1:0]         in_jmid,
   output logic                                out_valid,
   output logic [7:0]                          out_red,
   output logic [7:0]                          out_green,
   output logic [7:0]                          out_blue
);

   localparam int PRD_W = ttpc_pkg::WGT_W + 8;
   localparam int SUM_W = PRD_W + 1;

   // Stage one: edge flag, weights and colour lookups.
   logic [ttpc_pkg::LABEL_W-1:0]   l1;
   logic [ttpc_pkg::LABEL_W-1:0]   l2;
   logic [ttpc_pkg::LABEL_W-1:0]   l3;
   logic [3:0]                     mask;
   ttpc_pkg::slot_type             face_slot;

   logic                           v1_ff;
   logic                           edge1_ff;
   logic [ttpc_pkg::WGT_W-1:0]     w1_ff;
   logic [ttpc_pkg::WGT_W-1:0]     w2_ff;
   logic [ttpc_pkg::WGT_W-1:0]     w3_ff;
   logic [ttpc_pkg::COLOUR_W-1:0]  c1_ff;
   logic [ttpc_pkg::COLOUR_W-1:0]  c2_ff;
   logic [ttpc_pkg::COLOUR_W-1:0]  c3_ff;
   logic [ttpc_pkg::COLOUR_W-1:0]  face1_ff;

   assign l1   = in_labels[3*ttpc_pkg::LABEL_W-1:2*ttpc_pkg::LABEL_W];
   assign l2   = in_labels[2*ttpc_pkg::LABEL_W-1:ttpc_pkg::LABEL_W];
   assign l3   = in_labels[ttpc_pkg::LABEL_W-1:0];
   assign mask = (4'b0001 << l1) | (4'b0001 << l2) | (4'b0001 << l3);

   // The face takes the colour of the one label its corners lack.
   always_comb begin
      case (mask)
         ttpc_pkg::MASK_NO_A: face_slot = ttpc_pkg::SLOT_A;
         ttpc_pkg::MASK_NO_B: face_slot = ttpc_pkg::SLOT_B;
         ttpc_pkg::MASK_NO_C: face_slot = ttpc_pkg::SLOT_C;
         default:             face_slot = ttpc_pkg::SLOT_D;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      edge1_ff <= in_yz || ({1'b0, in_nr} == in_jmid);
      w1_ff    <= ttpc_pkg::WGT_W'(17'h10000 - {1'b0, in_d12} - in_d13);
      w2_ff    <= {1'b0, in_d12};
      w3_ff    <= in_d13;
      c1_ff    <= cfg.colour[l1];
      c2_ff    <= cfg.colour[l2];
      c3_ff    <= cfg.colour[l3];
      face1_ff <= cfg.colour[face_slot];
   end

   // Stage two: weighted channel products.
   logic                           v2_ff;
   logic                           edge2_ff;
   logic [ttpc_pkg::COLOUR_W-1:0]  face2_ff;
   logic [PRD_W-1:0]               pa_ff [3];
   logic [PRD_W-1:0]               pb_ff [3];
   logic [PRD_W-1:0]               pc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      edge2_ff <= edge1_ff;
      face2_ff <= face1_ff;
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_prod
      always_ff @(posedge clock) begin
         pa_ff[ch] <= PRD_W'(w1_ff * c1_ff[23-8*ch -: 8]);
         pb_ff[ch] <= PRD_W'(w2_ff * c2_ff[23-8*ch -: 8]);
         pc_ff[ch] <= PRD_W'(w3_ff * c3_ff[23-8*ch -: 8]);
      end
   end

   // Stage three: sum, drop the fraction, clamp and pick the output.
   logic       v3_ff;
   logic [7:0] chan_ff [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_sum
      logic [SUM_W-1:0] sum;
      logic [SUM_W-17:0] whole;
      logic [7:0]       blend;
      logic [7:0]       chan_in;

      assign sum   = SUM_W'(pa_ff[ch]) + SUM_W'(pb_ff[ch]) + SUM_W'(pc_ff[ch]);
      assign whole = sum[SUM_W-1:16];
      assign blend = (whole > (SUM_W-16)'(255)) ? 8'hFF : whole[7:0];

      always_comb begin
         if (cfg.edge_mark && edge2_ff) begin
            chan_in = 8'h00;
         end else if (cfg.vertex_mode) begin
            chan_in = blend;
         end else begin
            chan_in = face2_ff[23-8*ch -: 8];
         end
      end

      always_ff @(posedge clock) begin
         chan_ff[ch] <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_red   = chan_ff[0];
   assign out_green = chan_ff[1];
   assign out_blue  = chan_ff[2];

endmodule

// ----- rtl/core/ttpc_checker.sv -----
// Port-level checks on the pixel pipeline.
module ttpc_checker #(
   parameter int COORD_BITS = ttpc_pkg::COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   localparam int LAT = ttpc_pkg::latency(COORD_BITS);

   // Reset flushes every beat in flight.
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Every accepted pixel yields its result beat at the latency that ttpc_pkg::latency gives.
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted pixel produced no result beat");

   // No result beat appears without a matching accepted pixel.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result beat without an accepted pixel");

   // The pipeline never pushes back on the requester.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind triangle_tiling_pixel_colour_unit ttpc_checker #(.COORD_BITS(COORD_BITS)) u_ttpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
